FILE: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check that an expression is never true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

FILE: src/hsu_pkg.sv
// Types and constants of the hypotenuse square-root unit.
package hsu_pkg;

  localparam int LEG_BITS  = 16;
  localparam int FRAC_BITS = 16;
  localparam int HYP_BITS  = LEG_BITS + 1 + FRAC_BITS;
  localparam int SQ_BITS   = 2 * LEG_BITS;
  localparam int SUM_BITS  = SQ_BITS + 1;
  // Radicand is padded to whole bit pairs; fraction pairs shift in as zeros.
  localparam int RAD_BITS  = 2 * ((SUM_BITS + 1) / 2);
  localparam int REM_BITS  = HYP_BITS + 1;
  localparam int WORK_BITS = REM_BITS + 2;
  // One cell per root bit.
  localparam int DIGITS    = HYP_BITS;
  // Square stage, sum stage, then the cell row.
  localparam int LATENCY   = DIGITS + 2;

  typedef struct packed {
    logic [LEG_BITS-1:0] leg_a;
    logic [LEG_BITS-1:0] leg_b;
  } in_t;

  typedef struct packed {
    logic [HYP_BITS-1:0] hypotenuse;
    logic                legs_invalid;
  } out_t;

  // Partial state that moves from one cell to the next.
  typedef struct packed {
    logic                valid;
    logic                invalid;
    logic [RAD_BITS-1:0] rad;
    logic [REM_BITS-1:0] rem;
    logic [HYP_BITS-1:0] root;
  } cell_t;

endpackage

FILE: src/hsu_front.sv
// Front end: squares the legs, sums them and flags a zero leg.
module hsu_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  hsu_pkg::in_t  in_data,
  output hsu_pkg::cell_t cell_out
);

  logic                         sq_valid_r;
  logic                         sq_invalid_r;
  logic [hsu_pkg::SQ_BITS-1:0]  sq_a_r;
  logic [hsu_pkg::SQ_BITS-1:0]  sq_b_r;
  logic [hsu_pkg::SQ_BITS-1:0]  leg_a_ext;
  logic [hsu_pkg::SQ_BITS-1:0]  leg_b_ext;
  logic                         sum_valid_r;
  logic                         sum_invalid_r;
  logic [hsu_pkg::SUM_BITS-1:0] sum_r;
  logic [hsu_pkg::SUM_BITS-1:0] sum_nxt;

  // Widen the legs to the square width before the multiply.
  assign leg_a_ext = {{(hsu_pkg::SQ_BITS - hsu_pkg::LEG_BITS){1'b0}}, in_data.leg_a};
  assign leg_b_ext = {{(hsu_pkg::SQ_BITS - hsu_pkg::LEG_BITS){1'b0}}, in_data.leg_b};

  // Square both legs on transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_valid_r <= 1'b0;
    end else begin
      sq_valid_r <= accept;
    end
    sq_invalid_r <= (in_data.leg_a == '0) || (in_data.leg_b == '0);
    sq_a_r       <= leg_a_ext * leg_a_ext;
    sq_b_r       <= leg_b_ext * leg_b_ext;
  end

  // Drop the sum to zero for a zero leg, so the root comes out zero.
  always_comb begin
    sum_nxt = {1'b0, sq_a_r} + {1'b0, sq_b_r};
    if (sq_invalid_r) begin
      sum_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_valid_r <= 1'b0;
    end else begin
      sum_valid_r <= sq_valid_r;
    end
    sum_invalid_r <= sq_invalid_r;
    sum_r         <= sum_nxt;
  end

  assign cell_out.valid   = sum_valid_r;
  assign cell_out.invalid = sum_invalid_r;
  assign cell_out.rad     = {{(hsu_pkg::RAD_BITS - hsu_pkg::SUM_BITS){1'b0}}, sum_r};
  assign cell_out.rem     = '0;
  assign cell_out.root    = '0;

endmodule

FILE: src/hsu_cell.sv
// One cell of the square-root row: retires one radicand pair, one root bit.
module hsu_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  hsu_pkg::cell_t cell_in,
  output hsu_pkg::cell_t cell_out
);

  logic [1:0]                    pair;
  logic [hsu_pkg::WORK_BITS-1:0] work;
  logic [hsu_pkg::WORK_BITS-1:0] trial;
  logic [hsu_pkg::WORK_BITS-1:0] diff;
  logic                          bit_set;
  logic [hsu_pkg::REM_BITS-1:0]  rem_nxt;
  logic [hsu_pkg::HYP_BITS-1:0]  root_nxt;
  logic [hsu_pkg::RAD_BITS-1:0]  rad_nxt;
  logic                          valid_r;
  logic                          invalid_r;
  logic [hsu_pkg::RAD_BITS-1:0]  rad_r;
  logic [hsu_pkg::REM_BITS-1:0]  rem_r;
  logic [hsu_pkg::HYP_BITS-1:0]  root_r;

  // Bring in the top pair and test the trial subtrahend 4*root+1.
  always_comb begin
    pair     = cell_in.rad[hsu_pkg::RAD_BITS-1 -: 2];
    work     = {cell_in.rem, pair};
    trial    = {1'b0, cell_in.root, 2'b01};
    diff     = work - trial;
    bit_set  = (work >= trial);
    rem_nxt  = bit_set ? diff[hsu_pkg::REM_BITS-1:0] : work[hsu_pkg::REM_BITS-1:0];
    root_nxt = {cell_in.root[hsu_pkg::HYP_BITS-2:0], bit_set};
    rad_nxt  = {cell_in.rad[hsu_pkg::RAD_BITS-3:0], 2'b00};
  end

  // Advance to the next cell every cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cell_in.valid;
    end
    invalid_r <= cell_in.invalid;
    rad_r     <= rad_nxt;
    rem_r     <= rem_nxt;
    root_r    <= root_nxt;
  end

  assign cell_out.valid   = valid_r;
  assign cell_out.invalid = invalid_r;
  assign cell_out.rad     = rad_r;
  assign cell_out.rem     = rem_r;
  assign cell_out.root    = root_r;

endmodule

FILE: src/hypotenuse_sqrt_unit.sv
// Top level of the hypotenuse square-root unit.
// Accepts one leg pair per clock: busy never rises, so start may be held high
// every cycle. Each transfer gives exactly one result, registered through the
// two front stages that square and sum, then one cell per root bit, 33 cells, and
// shown on out_data for a single cycle with out_strobe high; the receiver
// cannot stall and must take it then. hypotenuse is floor(sqrt(a*a+b*b))
// with 16 fractional bits; a zero leg sets legs_invalid and gives zero.
module hypotenuse_sqrt_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  hsu_pkg::in_t  in_data,
  output logic          out_strobe,
  output hsu_pkg::out_t out_data
);

  hsu_pkg::cell_t chain [0:hsu_pkg::DIGITS];
  logic           accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  hsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_data  (in_data),
    .cell_out (chain[0])
  );

  // Row of digit cells, most significant root bit first.
  for (genvar i = 0; i < hsu_pkg::DIGITS; i++) begin : g_cell
    hsu_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_in  (chain[i]),
      .cell_out (chain[i+1])
    );
  end

  assign out_strobe              = chain[hsu_pkg::DIGITS].valid;
  assign out_data.hypotenuse     = chain[hsu_pkg::DIGITS].root;
  assign out_data.legs_invalid   = chain[hsu_pkg::DIGITS].invalid;

endmodule

FILE: src/hsu_checker.sv
// Port checker for the hypotenuse square-root unit, bound to the top level.
`include "assert_macros.svh"

module hsu_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input hsu_pkg::in_t  in_data,
  input logic          out_strobe,
  input hsu_pkg::out_t out_data
);

  localparam int LAT = hsu_pkg::LATENCY;

  `ASSERT_NEVER(a_never_busy, clk, rst_n, busy, "busy rose")
  `ASSERT_CLK(a_result_follows, clk, rst_n, (start && !busy) |-> ##LAT out_strobe, "result missing after transfer")
  `ASSERT_CLK(a_zero_leg, clk, rst_n, (start && !busy && (in_data.leg_a == '0 || in_data.leg_b == '0)) |-> ##LAT (out_data.legs_invalid && out_data.hypotenuse == '0), "zero leg not flagged")
  `ASSERT_CLK(a_good_legs, clk, rst_n, (start && !busy && in_data.leg_a != '0 && in_data.leg_b != '0) |-> ##LAT !out_data.legs_invalid, "valid legs flagged")

endmodule

bind hypotenuse_sqrt_unit hsu_checker u_hsu_checker (.*);
